### rtl/mbsd_pkg.sv
// types and constants shared by the midi byte stream decoder
// no dependencies
`default_nettype none

package mbsd_pkg;

    localparam logic [7:0] STATUS_MASK = 8'h80;

    localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
    localparam logic [3:0] CMD_POLY_PRESS = 4'hA;
    localparam logic [3:0] CMD_CONTROL    = 4'hB;
    localparam logic [3:0] CMD_PROGRAM    = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
    localparam logic [3:0] CMD_PITCH_BEND = 4'hE;
    localparam logic [3:0] CMD_SYSTEM     = 4'hF;

    localparam logic [3:0] SYS_SONG_POS   = 4'h2;
    localparam logic [3:0] SYS_SONG_SEL   = 4'h3;
    localparam logic [3:0] SYS_BUS_SEL    = 4'h5;
    localparam logic [3:0] SYS_TUNE_REQ   = 4'h6;
    localparam logic [3:0] SYS_CLOCK      = 4'h8;
    localparam logic [3:0] SYS_START      = 4'hA;
    localparam logic [3:0] SYS_CONTINUE   = 4'hB;
    localparam logic [3:0] SYS_STOP       = 4'hC;
    localparam logic [3:0] SYS_SENSING    = 4'hE;
    localparam logic [3:0] SYS_RESET      = 4'hF;

    localparam logic [1:0] DATA_TWO = 2'(3 - 1);
    localparam logic [1:0] DATA_ONE = 2'(2 - 1);

    typedef struct packed {
        logic       collecting;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic [1:0] remaining;
        logic [1:0] position;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic [1:0] length;
    } t_result;

endpackage

`default_nettype wire

### rtl/mbsd_parse.sv
// per-word parse step: next parser state and the finished message, if any
// depends on mbsd_pkg
`default_nettype none

module mbsd_parse (
    input  wire logic [7:0]      i_byte,
    input  wire mbsd_pkg::t_state i_state,
    output mbsd_pkg::t_state     o_state,
    output mbsd_pkg::t_result    o_result
);
    import mbsd_pkg::*;

    logic       status_seen;
    logic [3:0] cmd;
    logic [3:0] sub;
    logic [1:0] rem_dec;
    logic [1:0] pos_inc;
    t_state     cleared;
    t_state     gathered;

    assign status_seen = (i_byte & STATUS_MASK) != 8'h00;
    assign cmd         = i_byte[7:4];
    assign sub         = i_byte[3:0];
    assign rem_dec     = i_state.remaining - 2'd1;
    assign pos_inc     = i_state.position + 2'd1;
    assign cleared     = '0;

    always_comb begin
        gathered           = i_state;
        gathered.remaining = rem_dec;
        gathered.position  = pos_inc;
        case (i_state.position)
            2'd0:    gathered.status = i_state.status | i_byte;
            2'd1:    gathered.data1  = i_state.data1 | i_byte[6:0];
            2'd2:    gathered.data2  = i_state.data2 | i_byte[6:0];
            default: gathered        = gathered;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.collecting && !status_seen && i_state.remaining != 2'd0) begin
            if (rem_dec == 2'd0) begin
                o_state         = cleared;
                o_result.valid  = 1'b1;
                o_result.status = gathered.status;
                o_result.data1  = gathered.data1;
                o_result.data2  = gathered.data2;
                o_result.length = pos_inc;
            end else begin
                o_state = gathered;
            end
        end else if (!status_seen) begin
            o_state = cleared;
        end else begin
            o_state = cleared;
            unique case (cmd)
                CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRESS, CMD_CONTROL: begin
                    o_state.collecting = 1'b1;
                    o_state.status     = i_byte;
                    o_state.remaining  = DATA_TWO;
                    o_state.position   = 2'd1;
                end
                CMD_PROGRAM, CMD_CHAN_PRESS, CMD_PITCH_BEND: begin
                    o_state.collecting = 1'b1;
                    o_state.status     = i_byte;
                    o_state.remaining  = DATA_ONE;
                    o_state.position   = 2'd1;
                end
                CMD_SYSTEM: begin
                    case (sub) inside
                        SYS_SONG_POS: begin
                            o_state.collecting = 1'b1;
                            o_state.status     = i_byte;
                            o_state.remaining  = DATA_TWO;
                            o_state.position   = 2'd1;
                        end
                        SYS_SONG_SEL, SYS_BUS_SEL: begin
                            o_state.collecting = 1'b1;
                            o_state.status     = i_byte;
                            o_state.remaining  = DATA_ONE;
                            o_state.position   = 2'd1;
                        end
                        SYS_TUNE_REQ, SYS_CLOCK, SYS_START, SYS_CONTINUE,
                        SYS_STOP, SYS_SENSING, SYS_RESET: begin
                            o_result.valid  = 1'b1;
                            o_result.status = i_byte;
                            o_result.length = 2'd1;
                        end
                        default: o_state = cleared;
                    endcase
                end
                default: o_state = cleared;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/midi_byte_stream_decoder.sv
// midi byte stream decoder top level: input register, parser state, result register
// depends on mbsd_pkg and mbsd_parse
`default_nettype none

// Takes one MIDI byte per word and gives out each completed message (status byte,
// up to two data bytes and its length) as one result word. One word is taken every
// cycle while o_stall is low. A word is first held in the input register; then the
// parse step writes its result, if it has one, into the result register once that
// register is not stalled, and the receiver takes it from there. The parse step
// between them is a single pass over the byte and the parser state. While the result
// register is stalled, the input register holds one more word before o_stall rises.
// There is no running status; SysEx and undefined status bytes drop a partial
// message and give nothing.
module midi_byte_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_midi_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_status_byte,
    output logic [6:0]      o_first_data,
    output logic [6:0]      o_second_data,
    output logic [1:0]      o_message_length
);
    import mbsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       r_out_valid;
    logic [7:0] r_out_status;
    logic [6:0] r_out_data1;
    logic [6:0] r_out_data2;
    logic [1:0] r_out_length;
    logic       out_blocked;
    logic       proc_fire;

    assign out_blocked = r_out_valid && i_stall;
    assign proc_fire   = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;

    mbsd_parse u_parse (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_midi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_state     <= n_state;
            r_out_valid <= n_result.valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_status <= n_result.status;
            r_out_data1  <= n_result.data1;
            r_out_data2  <= n_result.data2;
            r_out_length <= n_result.length;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status_byte    = r_out_status;
    assign o_first_data     = r_out_data1;
    assign o_second_data    = r_out_data2;
    assign o_message_length = r_out_length;

    a_stall_needs_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("stall raised without a held word behind a stalled result");

    a_collect_has_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.collecting |-> (r_state.remaining != 2'd0 && r_state.position != 2'd0))
        else $error("collecting with no data bytes expected");

    a_result_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_message_length != 2'd0 && o_status_byte[7]))
        else $error("result word with bad length or status byte");

    a_short_message_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_length != 2'd3) |-> (o_second_data == 7'd0))
        else $error("second data byte set in a short message");

endmodule

`default_nettype wire
